// ===== sv/dpp_pkg.sv =====
// Shared types, constants and helper functions for the depth-pixel-to-point block.
// Holds the register map, the camera setup struct, the sequencer states and
// the fixed-point widths used by every module of the block.
package dpp_pkg;

  // Field widths of the streams and registers.
  localparam int DEPTH_W   = 16;
  localparam int COLOR_W   = 8;
  localparam int DIM_W     = 13;
  localparam int CENTER_W  = 16;
  localparam int INV_W     = 24;
  localparam int PT_W      = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  // Shared multiplier: a 32 x 26 product plus a 24-bit addend.
  localparam int MUL_A_W   = 32;
  localparam int MUL_B_W   = 26;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_ADD_W = 24;
  localparam int MUL_Y_W   = MUL_P_W + 1;

  // Offset magnitude times forward distance, split into two 26-bit halves.
  localparam int MAG_P_W   = 2 * MUL_B_W;
  // Low half times reciprocal, and the merged high-half sum.
  localparam int ACC_W     = 51;
  // Projected magnitude after dropping the two remaining fraction bits.
  localparam int RES_W     = ACC_W - 2;

  // Saturation limits of a signed Q16.16 result.
  localparam logic [PT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [PT_W-1:0] SAT_NEG = 32'h8000_0000;

  // Register reset values.
  localparam logic [DIM_W-1:0]    FRAME_WIDTH_RST  = 13'd1280;
  localparam logic [DIM_W-1:0]    FRAME_HEIGHT_RST = 13'd720;
  localparam logic [CENTER_W-1:0] CENTER_X_RST     = 16'd10240;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST     = 16'd5760;
  localparam logic [INV_W-1:0]    INV_FOCAL_RST    = 24'd0;
  localparam logic [INV_W-1:0]    INV_DEPTH_RST    = 24'd33554;

  // Register map of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH     = 3'd0,
    REG_FRAME_HEIGHT    = 3'd1,
    REG_CENTER_X        = 3'd2,
    REG_CENTER_Y        = 3'd3,
    REG_INV_FOCAL_X     = 3'd4,
    REG_INV_FOCAL_Y     = 3'd5,
    REG_INV_DEPTH_SCALE = 3'd6
  } cfg_reg_t;

  // Camera setup as held in the configuration registers.
  typedef struct packed {
    logic [DIM_W-1:0]    frame_width;
    logic [DIM_W-1:0]    frame_height;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [INV_W-1:0]    inv_focal_x;
    logic [INV_W-1:0]    inv_focal_y;
    logic [INV_W-1:0]    inv_depth_scale;
  } cam_cfg_t;

  // One pixel request without its frame-start flag.
  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [DEPTH_W-1:0] depth;
  } pixel_t;

  // One point result, last field in the lowest bits.
  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [PT_W-1:0]    vertical;
    logic [PT_W-1:0]    lateral;
    logic [PT_W-1:0]    forward;
  } point_t;

  // Operands of the shared multiply-add unit.
  typedef struct packed {
    logic [MUL_A_W-1:0]   a;
    logic [MUL_B_W-1:0]   b;
    logic [MUL_ADD_W-1:0] addend;
  } mul_op_t;

  // Sequencer steps, one multiplier pass per busy step from ST_FWD to ST_HI_Y.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FWD,
    ST_MAG_X,
    ST_LO_X,
    ST_HI_X,
    ST_MAG_Y,
    ST_LO_Y,
    ST_HI_Y,
    ST_PUSH
  } seq_state_t;

  // Applies the sign to a projected magnitude and clamps to signed 32 bits.
  function automatic logic [PT_W-1:0] sat_offset(input logic [RES_W-1:0] res,
                                                  input logic neg);
    if (neg) begin
      if (res >= RES_W'(SAT_NEG)) return SAT_NEG;
      return PT_W'(0) - res[PT_W-1:0];
    end
    if (res > RES_W'(SAT_POS)) return SAT_POS;
    return res[PT_W-1:0];
  endfunction

endpackage

// ===== sv/depth_pixel_to_point.sv =====
// Top level of the depth-pixel-to-point block: configuration registers and
// stream ports. Depends on dpp_pkg; instantiates dpp_pos and dpp_seq.
//
//   channel  direction  handshake            payload
//   in_      slave      in_tvalid/in_tready  depth and colour, frame start in tuser
//   out_     master     out_tvalid/out_tready forward, lateral, vertical, colour
//   cfg_     slave      cfg_valid/cfg_ready  register index and data
//
// A pixel with nonzero depth runs from one request to the next through the
// accept step, seven passes through the single 32 x 26 multiplier and a
// step to load the output register. A zero-depth pixel stays in the idle step.
// Reset is synchronous and active low; it restores the register defaults and
// clears the counters. A stalled output holds the sequencer in its last step.
module depth_pixel_to_point #(
  parameter int MAX_DIM_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // depth_sample[15:0], blue_in[23:16], green_in[31:24], red_in[39:32]
  input  logic [39:0]                       in_tdata,
  // frame_start[0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // point_forward[31:0], point_lateral[63:32], point_vertical[95:64],
  // blue_out[103:96], green_out[111:104], red_out[119:112]
  output logic [119:0]                      out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dpp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dpp_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import dpp_pkg::*;

  cam_cfg_t                cam_r;
  pixel_t                  pixel;
  point_t                  point;
  logic [MAX_DIM_BITS-1:0] col, row;
  logic                    in_accept;

  assign cfg_ready = 1'b1;
  assign pixel     = pixel_t'(in_tdata);
  assign in_accept = in_tvalid && in_tready;
  assign out_tdata = point;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r.frame_width     <= FRAME_WIDTH_RST;
      cam_r.frame_height    <= FRAME_HEIGHT_RST;
      cam_r.center_x        <= CENTER_X_RST;
      cam_r.center_y        <= CENTER_Y_RST;
      cam_r.inv_focal_x     <= INV_FOCAL_RST;
      cam_r.inv_focal_y     <= INV_FOCAL_RST;
      cam_r.inv_depth_scale <= INV_DEPTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:     cam_r.frame_width     <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT:    cam_r.frame_height    <= cfg_data[DIM_W-1:0];
        REG_CENTER_X:        cam_r.center_x        <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:        cam_r.center_y        <= cfg_data[CENTER_W-1:0];
        REG_INV_FOCAL_X:     cam_r.inv_focal_x     <= cfg_data[INV_W-1:0];
        REG_INV_FOCAL_Y:     cam_r.inv_focal_y     <= cfg_data[INV_W-1:0];
        REG_INV_DEPTH_SCALE: cam_r.inv_depth_scale <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // Raster position of each accepted pixel.
  dpp_pos #(
    .MAX_DIM_BITS (MAX_DIM_BITS)
  ) u_pos (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .frame_start  (in_tuser),
    .frame_width  (cam_r.frame_width),
    .frame_height (cam_r.frame_height),
    .col          (col),
    .row          (row)
  );

  // Projection sequencer with the shared multiplier and output register.
  dpp_seq #(
    .MAX_DIM_BITS (MAX_DIM_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .pixel     (pixel),
    .col       (col),
    .row       (row),
    .cam       (cam_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .point     (point)
  );

`ifndef ASSERT_OFF
  // A pixel with depth goes busy for its multiplier passes.
  a_busy_after_point: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_tdata[15:0] != 16'd0)) |=> !in_tready)
    else $error("block ready right after a pixel with depth");

  // A zero-depth pixel leaves the block ready for the next request.
  a_ready_after_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_tdata[15:0] == 16'd0)) |=> in_tready)
    else $error("block busy after a zero-depth pixel");

  // A new result only appears at the end of a busy stretch.
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a pixel in work");
`endif

endmodule

// ===== sv/dpp_mac.sv =====
// Shared multiply-add unit of the depth-pixel-to-point block.
// Depends on dpp_pkg for the operand struct and widths.
module dpp_mac (
  input  dpp_pkg::mul_op_t               op,
  output logic [dpp_pkg::MUL_Y_W-1:0]    y
);
  import dpp_pkg::*;

  logic [MUL_P_W-1:0] prod;

  // One 32 x 26 product, then the addend folded in.
  always_comb begin
    prod = op.a * op.b;
    y    = MUL_Y_W'(prod) + MUL_Y_W'(op.addend);
  end

endmodule

// ===== sv/dpp_pos.sv =====
// Column and row counters that track the raster position of each pixel.
// Depends on dpp_pkg for the frame-size width.
module dpp_pos #(
  parameter int MAX_DIM_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic                            frame_start,
  input  logic [dpp_pkg::DIM_W-1:0]       frame_width,
  input  logic [dpp_pkg::DIM_W-1:0]       frame_height,
  output logic [MAX_DIM_BITS-1:0]         col,
  output logic [MAX_DIM_BITS-1:0]         row
);
  import dpp_pkg::*;

  // Compare width: holds a count plus one and the full frame size.
  localparam int CW = (MAX_DIM_BITS + 1 > DIM_W) ? MAX_DIM_BITS + 1 : DIM_W;

  logic [MAX_DIM_BITS-1:0] col_r, col_nxt;
  logic [MAX_DIM_BITS-1:0] row_r, row_nxt;
  logic [CW-1:0]           col_inc, row_inc;
  logic                    col_wrap, row_wrap;

  // Position of the pixel being accepted; frame start forces the origin.
  assign col = frame_start ? '0 : col_r;
  assign row = frame_start ? '0 : row_r;

  // Advance the column, wrapping at the frame width or the counter range.
  always_comb begin
    col_inc  = CW'(col) + CW'(1);
    col_wrap = col_inc[MAX_DIM_BITS] || (col_inc >= CW'(frame_width));
    col_nxt  = col_wrap ? '0 : col_inc[MAX_DIM_BITS-1:0];
    row_inc  = CW'(row) + CW'(1);
    row_wrap = row_inc[MAX_DIM_BITS] || (row_inc >= CW'(frame_height));
    if (!col_wrap) begin
      row_nxt = row;
    end else if (row_wrap) begin
      row_nxt = '0;
    end else begin
      row_nxt = row_inc[MAX_DIM_BITS-1:0];
    end
  end

  // Counters move once per accepted pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== sv/dpp_seq.sv =====
// Sequencer that walks one pixel through the shared multiplier and holds the
// output register. Depends on dpp_pkg and instantiates dpp_mac.
module dpp_seq #(
  parameter int MAX_DIM_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  dpp_pkg::pixel_t              pixel,
  input  logic [MAX_DIM_BITS-1:0]      col,
  input  logic [MAX_DIM_BITS-1:0]      row,
  input  dpp_pkg::cam_cfg_t            cam,
  output logic                         out_valid,
  input  logic                         out_ready,
  output dpp_pkg::point_t              point
);
  import dpp_pkg::*;

  // Signed offset width and its magnitude width.
  localparam int SW   = (MAX_DIM_BITS + 6 > 18) ? MAX_DIM_BITS + 6 : 18;
  localparam int MAGW = SW - 1;

  seq_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_load;

  logic [DEPTH_W-1:0] depth_r;
  logic [COLOR_W-1:0] blue_r, green_r, red_r;
  logic               negx_r, negy_r;
  logic [MAGW-1:0]    magx_r, magy_r;
  logic [PT_W-1:0]    fwd_r, lat_r;
  logic [MAG_P_W-1:0] mag_r;
  logic [ACC_W-1:0]   acc_r;
  point_t             point_r;

  logic [SW-1:0]      off_x, off_y, abs_x, abs_y;
  mul_op_t            mul_op;
  logic [MUL_Y_W-1:0] mul_y;

  dpp_mac u_mac (
    .op (mul_op),
    .y  (mul_y)
  );

  // Q.4 offsets of the pixel from the principal point, as sign and magnitude.
  always_comb begin
    off_x = SW'({cam.frame_width, 4'b0000}) - SW'({col, 4'b0000}) - SW'(cam.center_x);
    off_y = SW'({cam.frame_height, 4'b0000}) - SW'({row, 4'b0000}) - SW'(cam.center_y);
    abs_x = off_x[SW-1] ? (~off_x + SW'(1)) : off_x;
    abs_y = off_y[SW-1] ? (~off_y + SW'(1)) : off_y;
  end

  // Operand select for the shared unit.
  always_comb begin
    mul_op = '0;
    unique case (state_r)
      ST_FWD: begin
        mul_op.a = MUL_A_W'(depth_r);
        mul_op.b = MUL_B_W'(cam.inv_depth_scale);
      end
      ST_MAG_X: begin
        mul_op.a = fwd_r;
        mul_op.b = MUL_B_W'(magx_r);
      end
      ST_MAG_Y: begin
        mul_op.a = fwd_r;
        mul_op.b = MUL_B_W'(magy_r);
      end
      ST_LO_X: begin
        mul_op.a = MUL_A_W'(cam.inv_focal_x);
        mul_op.b = mag_r[MUL_B_W-1:0];
      end
      ST_LO_Y: begin
        mul_op.a = MUL_A_W'(cam.inv_focal_y);
        mul_op.b = mag_r[MUL_B_W-1:0];
      end
      ST_HI_X: begin
        mul_op.a      = MUL_A_W'(cam.inv_focal_x);
        mul_op.b      = mag_r[MAG_P_W-1:MUL_B_W];
        mul_op.addend = acc_r[MUL_B_W+MUL_ADD_W-1:MUL_B_W];
      end
      ST_HI_Y: begin
        mul_op.a      = MUL_A_W'(cam.inv_focal_y);
        mul_op.b      = mag_r[MAG_P_W-1:MUL_B_W];
        mul_op.addend = acc_r[MUL_B_W+MUL_ADD_W-1:MUL_B_W];
      end
      default: mul_op = '0;
    endcase
  end

  // Next state and handshake outputs.
  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (pixel.depth != '0)) state_nxt = ST_FWD;
      end
      ST_FWD:   state_nxt = ST_MAG_X;
      ST_MAG_X: state_nxt = ST_LO_X;
      ST_LO_X:  state_nxt = ST_HI_X;
      ST_HI_X:  state_nxt = ST_MAG_Y;
      ST_MAG_Y: state_nxt = ST_LO_Y;
      ST_LO_Y:  state_nxt = ST_HI_Y;
      ST_HI_Y:  state_nxt = ST_PUSH;
      ST_PUSH: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers, each written only in the steps that fill it.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          depth_r <= pixel.depth;
          blue_r  <= pixel.blue;
          green_r <= pixel.green;
          red_r   <= pixel.red;
          negx_r  <= off_x[SW-1];
          negy_r  <= off_y[SW-1];
          magx_r  <= abs_x[MAGW-1:0];
          magy_r  <= abs_y[MAGW-1:0];
        end
      end
      ST_FWD: fwd_r <= mul_y[PT_W+7:8];
      ST_MAG_X: mag_r <= mul_y[MAG_P_W-1:0];
      ST_MAG_Y: begin
        mag_r <= mul_y[MAG_P_W-1:0];
        lat_r <= sat_offset(acc_r[ACC_W-1:2], negx_r);
      end
      ST_LO_X, ST_HI_X, ST_LO_Y, ST_HI_Y: acc_r <= mul_y[ACC_W-1:0];
      ST_PUSH: begin
        if (out_load) begin
          point_r.forward  <= fwd_r;
          point_r.lateral  <= lat_r;
          point_r.vertical <= sat_offset(acc_r[ACC_W-1:2], negy_r);
          point_r.blue     <= blue_r;
          point_r.green    <= green_r;
          point_r.red      <= red_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign point     = point_r;

endmodule
